>>> src/pkcs7psc_pkg.sv
// Shared constants and types for the PKCS#7 pad strip and check core.
package pkcs7psc_pkg;

  localparam int BLOCK = 16;
  localparam int HOLD  = BLOCK - 1;
  localparam int CNT_W = $clog2(BLOCK);

  typedef enum logic [1:0] {
    S_RUN,
    S_DRAIN,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic push;
    logic load_oldest;
    logic capture;
    logic load_drain;
    logic load_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic end_ok;
    logic end_payload;
    logic drain_last;
  } dp_sts_t;

endpackage

>>> src/pkcs7psc_dp.sv
// Datapath: hold-back shift line, pad check, drain pointer and output register.
module pkcs7psc_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pkcs7psc_pkg::ctl_cmd_t    cmd,
  output pkcs7psc_pkg::dp_sts_t     sts,
  input  logic [7:0]                data_byte,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      out_done,
  output logic [1:0]                out_flags
);

  logic [7:0]                     hist_r [pkcs7psc_pkg::HOLD];
  logic [pkcs7psc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [pkcs7psc_pkg::CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [pkcs7psc_pkg::CNT_W-1:0] stop_idx_r, stop_idx_nxt;
  logic                           ok_r, ok_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     out_byte_r, out_byte_nxt;
  logic                           out_done_r, out_done_nxt;
  logic [1:0]                     out_flags_r, out_flags_nxt;

  logic [pkcs7psc_pkg::HOLD-1:0]  match;
  logic [7:0]                     n_len;
  logic [pkcs7psc_pkg::CNT_W-1:0] v_m1;
  logic                           range_ok;
  logic                           pad_ok;

  always_comb begin
    for (int i = 0; i < pkcs7psc_pkg::HOLD; i++) begin
      match[i] = (hist_r[i] == data_byte) || (8'(i + 1) >= data_byte);
    end
  end

  assign n_len    = 8'(count_r) + 8'd1;
  assign v_m1     = data_byte[pkcs7psc_pkg::CNT_W-1:0] - 1'b1;
  assign range_ok = (data_byte != 8'd0) && (data_byte <= 8'(pkcs7psc_pkg::BLOCK)) &&
                    (data_byte <= n_len);
  assign pad_ok   = range_ok && (&match);

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.full        = (count_r == pkcs7psc_pkg::CNT_W'(pkcs7psc_pkg::HOLD));
  assign sts.end_ok      = pad_ok;
  assign sts.end_payload = (8'(count_r) >= data_byte);
  assign sts.drain_last  = (rd_idx_r == stop_idx_r);

  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    stop_idx_nxt  = stop_idx_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_done_nxt  = out_done_r;
    out_flags_nxt = out_flags_r;
    if (cmd.push && !sts.full) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.load_oldest) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hist_r[pkcs7psc_pkg::HOLD-1];
      out_done_nxt  = 1'b0;
      out_flags_nxt = 2'b01;
    end
    if (cmd.capture) begin
      ok_nxt       = pad_ok;
      rd_idx_nxt   = count_r - 1'b1;
      stop_idx_nxt = v_m1;
      count_nxt    = '0;
    end
    if (cmd.load_drain) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hist_r[rd_idx_r];
      out_done_nxt  = 1'b0;
      out_flags_nxt = 2'b01;
      rd_idx_nxt    = rd_idx_r - 1'b1;
    end
    if (cmd.load_status) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = 8'd0;
      out_done_nxt  = 1'b1;
      out_flags_nxt = {!ok_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_r[0] <= data_byte;
      for (int i = 1; i < pkcs7psc_pkg::HOLD; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    rd_idx_r    <= rd_idx_nxt;
    stop_idx_r  <= stop_idx_nxt;
    ok_r        <= ok_nxt;
    out_byte_r  <= out_byte_nxt;
    out_done_r  <= out_done_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_done  = out_done_r;
  assign out_flags = out_flags_r;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_oldest || cmd.load_drain || cmd.load_status) |-> sts.out_free)
    else $error("output register loaded while occupied");
  a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (count_r == '0))
    else $error("held count not cleared at message end");
  a_drain_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_drain |-> ok_r)
    else $error("payload drained after failed pad check");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pkcs7psc_pkg::CNT_W'(pkcs7psc_pkg::HOLD))
    else $error("held count beyond hold depth");
`endif

endmodule

>>> src/pkcs7psc_ctrl.sv
// Controller: accepts transactions, sequences the drain and the status item.
module pkcs7psc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_last,
  output logic                      in_ready,
  input  pkcs7psc_pkg::dp_sts_t     sts,
  output pkcs7psc_pkg::ctl_cmd_t    cmd
);

  pkcs7psc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pkcs7psc_pkg::S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pkcs7psc_pkg::S_RUN: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (!in_last) begin
            cmd.push        = 1'b1;
            cmd.load_oldest = sts.full;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = (sts.end_ok && sts.end_payload) ? pkcs7psc_pkg::S_DRAIN
                                                          : pkcs7psc_pkg::S_STATUS;
          end
        end
      end
      pkcs7psc_pkg::S_DRAIN: begin
        if (sts.out_free) begin
          cmd.load_drain = 1'b1;
          if (sts.drain_last) begin
            state_nxt = pkcs7psc_pkg::S_STATUS;
          end
        end
      end
      pkcs7psc_pkg::S_STATUS: begin
        if (sts.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = pkcs7psc_pkg::S_RUN;
        end
      end
      default: begin
        state_nxt = pkcs7psc_pkg::S_RUN;
      end
    endcase
  end

endmodule

>>> src/pkcs7_pad_strip_check_core.sv
// A held byte appears on the output in the cycle after the transaction that ages it out.
// Throughput: one byte per cycle while the message streams and the output is
// free; the hold depth of BLOCK-1 bytes sets the burst at message end: n-v payload
// bytes on valid padding plus one status item, during which no input is taken.
// Reset: synchronous active-low rst_n clears the held count, controller state
// and output valid; held bytes are not cleared.
module pkcs7_pad_strip_check_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_present, [1] pad_status
  output logic       out_tlast
);

  pkcs7psc_pkg::ctl_cmd_t cmd;
  pkcs7psc_pkg::dp_sts_t  sts;

  pkcs7psc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pkcs7psc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .data_byte (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_done  (out_tlast),
    .out_flags (out_tuser)
  );

endmodule
